@@ rtl/gas_sensor_ppm_converter_core_defines.svh @@
// ----------------------------------------------------------------------------
// gas sensor ppm converter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_PPM_CONVERTER_CORE_DEFINES_SVH
`define GAS_SENSOR_PPM_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication
`define GSPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gspc: implication check failed");

// next-cycle implication
`define GSPC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gspc: next-cycle check failed");

`endif

@@ rtl/gspc_pkg.sv @@
// ----------------------------------------------------------------------------
// gspc_pkg
// widths, constants, register codes and the exp2 table of the ppm converter
// ----------------------------------------------------------------------------
package gspc_pkg;

	localparam int unsigned SAMPLES_DEFAULT  = 10;
	localparam int unsigned ADC_BITS_DEFAULT = 12;

	localparam int SAMPLE_W  = 12;
	localparam int SUM_W     = 16;
	localparam int PPM_W     = 20;
	localparam int LOAD_W    = 17;
	localparam int BASE_W    = 20;
	localparam int COEF_W    = 24;
	localparam int EXPO_W    = 16;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int MV_W      = 13;

	localparam int NUM_W  = 48;
	localparam int DEN_W  = 34;
	localparam int OP_W   = 33;
	localparam int PROD_W = 66;
	localparam int MANT_W = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOAD = 2'd0,
		REG_BASE = 2'd1,
		REG_COEF = 2'd2,
		REG_EXPO = 2'd3
	} cfg_reg_t;

	localparam logic [LOAD_W-1:0]        LOAD_RST = 17'd2000;
	localparam logic [BASE_W-1:0]        BASE_RST = 20'd6640;
	localparam logic [COEF_W-1:0]        COEF_RST = 24'd147008;
	localparam logic signed [EXPO_W-1:0] EXPO_RST = -16'sd9101;

	localparam logic [MV_W-1:0]  MV_SCALE    = 13'd6600;
	localparam logic [MV_W-1:0]  MV_MAX      = 13'd4990;
	localparam logic [MV_W-1:0]  MV_MIN      = 13'd20;
	localparam logic [MV_W-1:0]  MV_FULL     = 13'd5000;
	localparam logic [NUM_W-1:0] RATIO_FLOOR = 48'd655;
	localparam logic [PPM_W-1:0] PPM_MAX     = 20'hFFFFF;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

	// 2^(2^k/1024) in Q30
	function automatic logic [MANT_W-1:0] exp2_entry(input logic [3:0] k);
		logic [MANT_W-1:0] v;
		case (k)
			4'd0:    v = 31'd1074468888;
			4'd1:    v = 31'd1075196444;
			4'd2:    v = 31'd1076653033;
			4'd3:    v = 31'd1079572136;
			4'd4:    v = 31'd1085434106;
			4'd5:    v = 31'd1097253708;
			4'd6:    v = 31'd1121280436;
			4'd7:    v = 31'd1170923762;
			4'd8:    v = 31'd1276901417;
			4'd9:    v = 31'd1518500250;
			default: v = 31'd1073741824;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/gspc_div.sv @@
// ----------------------------------------------------------------------------
// gspc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gspc_div import gspc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
				num_q  <= numer;
				rem_q  <= '0;
				den_q  <= denom;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				num_q <= {num_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

@@ rtl/gspc_mul.sv @@
// ----------------------------------------------------------------------------
// gspc_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module gspc_mul import gspc_pkg::*; (
	input  logic                     clk,
	input  logic signed [OP_W-1:0]   op_a,
	input  logic signed [OP_W-1:0]   op_b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

	assign prod = prod_q;

endmodule

@@ rtl/gspc_seq.sv @@
// ----------------------------------------------------------------------------
// gspc_seq
// reading sequencer: voltage, resistance ratio, log2, exp2 and scaling
// ----------------------------------------------------------------------------
module gspc_seq import gspc_pkg::*; #(
	parameter int unsigned SAMPLES_PER_READING = SAMPLES_DEFAULT,
	parameter int unsigned ADC_BITS            = ADC_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [SUM_W-1:0]         total,
	input  logic [LOAD_W-1:0]        load,
	input  logic [BASE_W-1:0]        base,
	input  logic [COEF_W-1:0]        coef,
	input  logic signed [EXPO_W-1:0] expo,
	input  logic                     res_take,
	output seq_stat_t                stat,
	output logic [PPM_W-1:0]         ppm,
	output logic                     sum_zero,
	output logic                     clamped
);

	localparam longint unsigned FS_L     = (64'd1 << ADC_BITS) - 64'd1;
	localparam logic [NUM_W-1:0] MV_BIAS = NUM_W'(SAMPLES_PER_READING * FS_L);
	localparam longint unsigned MV_DEN_L = 2 * SAMPLES_PER_READING * FS_L;
	// voltage numerator stays below 2^(SUM_W+MV_W), so this reciprocal is exact
	localparam int MV_K = SUM_W + MV_W + $clog2(MV_DEN_L);
	localparam longint unsigned MV_RECIP = ((64'd1 << MV_K) + MV_DEN_L - 64'd1) / MV_DEN_L;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MVMUL, ST_MVMUL_W, ST_MVREC, ST_MVDIV, ST_LMUL, ST_LMUL_W, ST_DMUL,
		ST_DMUL_W, ST_RDIV_GO, ST_RDIV, ST_NORM, ST_SQ, ST_SQ_W, ST_LR, ST_LR_W,
		ST_EXP, ST_EXP_W, ST_AMUL, ST_AMUL_W, ST_DONE
	} state_t;

	state_t                   state_q;
	logic [SUM_W-1:0]         total_q;
	logic [MV_W-1:0]          mv_q;
	logic [NUM_W-1:0]         acc_q;
	logic [DEN_W-1:0]         den_q;
	logic [NUM_W-1:0]         x_q;
	logic [5:0]               shift_q;
	logic [MANT_W-1:0]        m_q;
	logic [9:0]               frac_q;
	logic [3:0]               it_q;
	logic [9:0]               fexp_q;
	logic signed [12:0]       s_q;
	logic [MANT_W-1:0]        mant_q;
	logic [PPM_W-1:0]         ppm_q;
	logic                     zero_q;
	logic                     clamp_q;

	logic signed [OP_W-1:0]   op_a;
	logic signed [OP_W-1:0]   op_b;
	logic signed [PROD_W-1:0] prod;
	logic                     div_start;
	logic [NUM_W-1:0]         div_num;
	logic [DEN_W-1:0]         div_den;
	logic                     div_done;
	logic [NUM_W-1:0]         div_q;

	logic [BASE_W-1:0]        base_eff;
	logic [NUM_W-1:0]         mv_quo;
	logic signed [6:0]        pexp;
	logic signed [16:0]       lr_w;
	logic signed [33:0]       esum;
	logic signed [21:0]       t_w;
	logic signed [12:0]       s_w;
	logic [31:0]              sq_w;
	logic [5:0]               sh_w;
	logic [55:0]              shifted;
	logic [56:0]              rnd;

	gspc_mul u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	gspc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_num),
		.denom  (div_den),
		.done   (div_done),
		.quot   (div_q)
	);

	assign base_eff = (base == '0) ? BASE_W'(1) : base;
	assign mv_quo   = NUM_W'($unsigned(prod) >> MV_K);
	assign pexp     = 7'sd31 - $signed({1'b0, shift_q});
	assign lr_w     = {pexp, frac_q};
	assign esum     = prod[33:0] + 34'sd2048;
	assign t_w      = esum[33:12] - 22'sd4096;
	assign s_w      = 13'sd30 - $signed({t_w[21], t_w[21:10]});
	assign sq_w     = prod[61:30];
	assign sh_w     = s_q[5:0] - 6'd1;
	assign shifted  = prod[55:0] >> sh_w;
	assign rnd      = ({1'b0, shifted} + 57'd1) >> 1;

	always_comb begin
		op_a      = '0;
		op_b      = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			ST_MVMUL: begin
				op_a = OP_W'(MV_SCALE);
				op_b = OP_W'(total_q);
			end
			ST_MVREC: begin
				op_a = OP_W'(acc_q);
				op_b = OP_W'(MV_RECIP);
			end
			ST_LMUL: begin
				op_a = OP_W'(load);
				op_b = OP_W'(MV_FULL - mv_q);
			end
			ST_DMUL: begin
				op_a = OP_W'(mv_q);
				op_b = OP_W'(base_eff);
			end
			ST_RDIV_GO: begin
				div_start = 1'b1;
				div_num   = acc_q + NUM_W'(den_q >> 1);
				div_den   = den_q;
			end
			ST_SQ: begin
				op_a = OP_W'(m_q);
				op_b = OP_W'(m_q);
			end
			ST_LR: begin
				op_a = OP_W'(expo);
				op_b = OP_W'(lr_w);
			end
			ST_EXP: begin
				op_a = OP_W'(mant_q);
				op_b = OP_W'(exp2_entry(it_q));
			end
			ST_AMUL: begin
				op_a = OP_W'(coef);
				op_b = OP_W'(mant_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			mv_q    <= '0;
			acc_q   <= '0;
			den_q   <= '0;
			x_q     <= '0;
			shift_q <= '0;
			m_q     <= '0;
			frac_q  <= '0;
			it_q    <= '0;
			fexp_q  <= '0;
			s_q     <= '0;
			mant_q  <= '0;
			ppm_q   <= '0;
			zero_q  <= 1'b0;
			clamp_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						total_q <= total;
						clamp_q <= 1'b0;
						if (total == '0) begin
							zero_q  <= 1'b1;
							ppm_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							zero_q  <= 1'b0;
							state_q <= ST_MVMUL;
						end
					end
				end
				ST_MVMUL:   state_q <= ST_MVMUL_W;
				ST_MVMUL_W: begin
					acc_q   <= prod[NUM_W-1:0] + MV_BIAS;
					state_q <= ST_MVREC;
				end
				ST_MVREC:   state_q <= ST_MVDIV;
				ST_MVDIV: begin
					if (mv_quo > NUM_W'(MV_MAX)) begin
						mv_q    <= MV_MAX;
						clamp_q <= 1'b1;
					end else if (mv_quo < NUM_W'(MV_MIN)) begin
						mv_q    <= MV_MIN;
						clamp_q <= 1'b1;
					end else begin
						mv_q <= mv_quo[MV_W-1:0];
					end
					state_q <= ST_LMUL;
				end
				ST_LMUL: state_q <= ST_LMUL_W;
				ST_LMUL_W: begin
					acc_q   <= {prod[NUM_W-17:0], 16'd0};
					state_q <= ST_DMUL;
				end
				ST_DMUL: state_q <= ST_DMUL_W;
				ST_DMUL_W: begin
					den_q   <= prod[DEN_W-1:0];
					state_q <= ST_RDIV_GO;
				end
				ST_RDIV_GO: state_q <= ST_RDIV;
				ST_RDIV: begin
					if (div_done) begin
						x_q     <= (div_q == '0) ? RATIO_FLOOR : div_q;
						shift_q <= '0;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (x_q[NUM_W-1]) begin
						m_q     <= x_q[NUM_W-1 -: MANT_W];
						frac_q  <= '0;
						it_q    <= '0;
						state_q <= ST_SQ;
					end else begin
						x_q     <= {x_q[NUM_W-2:0], 1'b0};
						shift_q <= shift_q + 1'b1;
					end
				end
				ST_SQ: state_q <= ST_SQ_W;
				ST_SQ_W: begin
					frac_q <= {frac_q[8:0], sq_w[31]};
					m_q    <= sq_w[31] ? sq_w[31:1] : sq_w[30:0];
					if (it_q == 4'd9) begin
						it_q    <= '0;
						state_q <= ST_LR;
					end else begin
						it_q    <= it_q + 1'b1;
						state_q <= ST_SQ;
					end
				end
				ST_LR: state_q <= ST_LR_W;
				ST_LR_W: begin
					fexp_q  <= t_w[9:0];
					s_q     <= s_w;
					mant_q  <= 31'd1073741824;
					it_q    <= '0;
					state_q <= ST_EXP;
				end
				ST_EXP: begin
					if (it_q == 4'd10) begin
						state_q <= ST_AMUL;
					end else if (fexp_q[it_q]) begin
						state_q <= ST_EXP_W;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				ST_EXP_W: begin
					mant_q  <= prod[60:30];
					it_q    <= it_q + 1'b1;
					state_q <= ST_EXP;
				end
				ST_AMUL: state_q <= ST_AMUL_W;
				ST_AMUL_W: begin
					if (coef == '0) begin
						ppm_q <= '0;
					end else if (s_q <= 13'sd10) begin
						ppm_q <= PPM_MAX;
					end else if (s_q >= 13'sd56) begin
						ppm_q <= '0;
					end else if (rnd > 57'(PPM_MAX)) begin
						ppm_q <= PPM_MAX;
					end else begin
						ppm_q <= rnd[PPM_W-1:0];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign ppm       = ppm_q;
	assign sum_zero  = zero_q;
	assign clamped   = clamp_q;

endmodule

@@ rtl/gas_sensor_ppm_converter_core.sv @@
// a sample that does not close a group only updates the sum and the count
// a closing sample starts the sequencer, whose reading passes through one 48-step
// ratio division, the normalize shift, ten squarings and the exp2 steps;
// an all-zero group skips these steps and gives a zero reading directly
// throughput: one sample per cycle inside a group, one reading at a time; in_ready is low while a reading is in work
// reset: asynchronous, clears sum, count, sequencer and registers to defaults
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter_core
// sample accumulator, config registers and result register around the sequencer
// ----------------------------------------------------------------------------
module gas_sensor_ppm_converter_core import gspc_pkg::*; #(
	parameter int unsigned SAMPLES_PER_READING = SAMPLES_DEFAULT,
	parameter int unsigned ADC_BITS            = ADC_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SAMPLE_W-1:0]  adc_sample,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PPM_W-1:0]     ppm_q4,
	output logic                 sum_was_zero,
	output logic                 voltage_clamped
);

	localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);

	logic [LOAD_W-1:0]        load_q;
	logic [BASE_W-1:0]        base_q;
	logic [COEF_W-1:0]        coef_q;
	logic signed [EXPO_W-1:0] expo_q;
	logic [SUM_W-1:0]         sum_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     out_valid_q;
	logic [PPM_W-1:0]         ppm_q;
	logic                     zero_q;
	logic                     clamp_q;

	logic                     in_xfer;
	logic                     last;
	logic [SUM_W-1:0]         sum_next;
	logic                     res_take;
	seq_stat_t                stat;
	logic [PPM_W-1:0]         seq_ppm;
	logic                     seq_zero;
	logic                     seq_clamp;

	assign in_ready = stat.idle;
	assign in_xfer  = in_valid && in_ready;
	assign last     = (cnt_q == CNT_W'(SAMPLES_PER_READING - 1));
	assign sum_next = sum_q + SUM_W'(adc_sample);
	assign res_take = stat.done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= LOAD_RST;
			base_q <= BASE_RST;
			coef_q <= COEF_RST;
			expo_q <= EXPO_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_LOAD: load_q <= cfg_data[LOAD_W-1:0];
				REG_BASE: base_q <= cfg_data[BASE_W-1:0];
				REG_COEF: coef_q <= cfg_data[COEF_W-1:0];
				REG_EXPO: expo_q <= $signed(cfg_data[EXPO_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (in_xfer) begin
			if (last) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	gspc_seq #(
		.SAMPLES_PER_READING (SAMPLES_PER_READING),
		.ADC_BITS            (ADC_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_xfer && last),
		.total    (sum_next),
		.load     (load_q),
		.base     (base_q),
		.coef     (coef_q),
		.expo     (expo_q),
		.res_take (res_take),
		.stat     (stat),
		.ppm      (seq_ppm),
		.sum_zero (seq_zero),
		.clamped  (seq_clamp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ppm_q       <= '0;
			zero_q      <= 1'b0;
			clamp_q     <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
			ppm_q       <= seq_ppm;
			zero_q      <= seq_zero;
			clamp_q     <= seq_clamp;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign ppm_q4          = ppm_q;
	assign sum_was_zero    = zero_q;
	assign voltage_clamped = clamp_q;

endmodule

@@ rtl/gspc_checker.sv @@
// ----------------------------------------------------------------------------
// gspc_checker
// port-level checks of the ppm converter, bound to the top level
// ----------------------------------------------------------------------------
`include "gas_sensor_ppm_converter_core_defines.svh"

module gspc_checker import gspc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [PPM_W-1:0]     ppm_q4,
	input logic                 sum_was_zero,
	input logic                 voltage_clamped
);

	// stalled result holds
	`GSPC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ppm_q4))

	// zero group gives zero reading without clamp flag
	`GSPC_ASSERT_IMP(a_zero_result, out_valid && sum_was_zero, ppm_q4 == '0 && !voltage_clamped)

	// input side closes only after a transfer closing a group
	`GSPC_ASSERT_IMP(a_ready_fall, $fell(in_ready), $past(in_valid && in_ready))

endmodule

bind gas_sensor_ppm_converter_core gspc_checker u_gspc_checker (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// drives sample groups through the ppm converter under changing register
// settings and random stalls on both sides; every reading is checked field by
// field against a bit-accurate fixed-point power-law predictor
// ----------------------------------------------------------------------------
module tb_top;
	import gspc_pkg::*;

	localparam int GROUP       = 10;
	localparam int SETTLE      = 300;
	localparam longint LIMIT   = 3000000;

	typedef struct packed {
		logic [PPM_W-1:0] ppm;
		logic             zero;
		logic             clamp;
	} reading_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_LOAD;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [SAMPLE_W-1:0]  adc_sample = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [PPM_W-1:0]     ppm_q4;
	logic                 sum_was_zero;
	logic                 voltage_clamped;

	gas_sensor_ppm_converter_core dut (.*);

	always #1 clk = ~clk;

	logic [SAMPLE_W-1:0] pending_samples[$];
	reading_t            expected_readings[$];
	int                  errors = 0;
	longint              cycles = 0;
	bit                  in_taken = 0;
	bit                  hold = 0;
	int                  send_idle = 0;
	int                  recv_idle = 0;

	// predictor state
	logic [LOAD_W-1:0]  m_load;
	logic [BASE_W-1:0]  m_base;
	logic [COEF_W-1:0]  m_coef;
	logic [EXPO_W-1:0]  m_expo;
	logic [SUM_W-1:0]   m_sum;
	int                 m_count;

	longint unsigned exp2_steps[10] = '{
		64'd1074468888, 64'd1075196444, 64'd1076653033, 64'd1079572136,
		64'd1085434106, 64'd1097253708, 64'd1121280436, 64'd1170923762,
		64'd1276901417, 64'd1518500250};

	function automatic longint log2_fix(input longint unsigned r);
		int p;
		longint unsigned m;
		longint fr;
		p = 63;
		fr = 0;
		while (p > 0 && r[p] == 1'b0) p--;
		m = (p >= 30) ? (r >> (p - 30)) : (r << (30 - p));
		for (int k = 0; k < 10; k++) begin
			m = (m * m) >> 30;
			fr = fr << 1;
			if (m >= (64'd1 << 31)) begin
				fr = fr | 1;
				m = m >> 1;
			end
		end
		return longint'(p - 16) * 1024 + fr;
	endfunction

	function automatic logic [PPM_W-1:0] ppm_of_ratio(input longint unsigned ratio);
		longint b, lr, e, t, i, s;
		longint unsigned f, mant, res;
		b = longint'($signed(m_expo));
		lr = log2_fix(ratio);
		e = (b * lr + 2048) >>> 12;
		t = e - 4096;
		i = t >>> 10;
		f = longint'(t) & 1023;
		mant = 64'd1 << 30;
		for (int k = 0; k < 10; k++)
			if (f[k]) mant = (mant * exp2_steps[k]) >> 30;
		if (m_coef == 0) return '0;
		s = 30 - i;
		if (s <= 10) return PPM_MAX;
		if (s >= 56) return '0;
		res = (longint'(m_coef) * mant + (64'd1 << (s - 1))) >> s;
		return (res > PPM_MAX) ? PPM_MAX : res[PPM_W-1:0];
	endfunction

	function automatic void predict_sample(input logic [SAMPLE_W-1:0] smp);
		longint unsigned total, mv, num, den, base, ratio;
		reading_t r;
		m_sum = m_sum + smp;
		m_count++;
		if (m_count < GROUP) return;
		total = m_sum;
		m_sum = '0;
		m_count = 0;
		r = '0;
		if (total == 0) begin
			r.zero = 1'b1;
		end else begin
			mv = (2 * 3300 * total + GROUP * 4095) / (2 * GROUP * 4095);
			if (mv > 4990) begin
				mv = 4990;
				r.clamp = 1'b1;
			end else if (mv < 20) begin
				mv = 20;
				r.clamp = 1'b1;
			end
			base = (m_base == 0) ? 1 : m_base;
			num = longint'(m_load) * (5000 - mv) * 65536;
			den = mv * base;
			ratio = (num + den / 2) / den;
			if (ratio == 0) ratio = 655;
			r.ppm = ppm_of_ratio(ratio);
		end
		expected_readings.push_back(r);
	endfunction

	task automatic report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	// monitor: input transfers, output check and cycle limit
	always @(posedge clk) begin
		reading_t want;
		cycles++;
		if (cycles > LIMIT) begin
			$display("gas_sensor_ppm_converter_core verification failed");
			$finish;
		end
		in_taken = in_valid && in_ready;
		if (in_taken) begin
			predict_sample(adc_sample);
			void'(pending_samples.pop_front());
		end
		if (out_valid && out_ready) begin
			if (expected_readings.size() == 0) begin
				report($sformatf("unexpected reading ppm=%0d", ppm_q4));
			end else begin
				want = expected_readings.pop_front();
				if (ppm_q4 !== want.ppm)
					report($sformatf("ppm_q4 got %0d want %0d", ppm_q4, want.ppm));
				if (sum_was_zero !== want.zero)
					report($sformatf("sum_was_zero got %b want %b", sum_was_zero, want.zero));
				if (voltage_clamped !== want.clamp)
					report($sformatf("voltage_clamped got %b want %b", voltage_clamped,
						want.clamp));
			end
		end
	end

	// driver
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pending_samples.size() > 0 && !hold && $urandom_range(99) >= send_idle) begin
				in_valid <= 1'b1;
				adc_sample <= pending_samples[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_LOAD: m_load = val[LOAD_W-1:0];
			REG_BASE: m_base = val[BASE_W-1:0];
			REG_COEF: m_coef = val[COEF_W-1:0];
			REG_EXPO: m_expo = val[EXPO_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || expected_readings.size() > 0 || in_valid)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_group(input int kind, input logic [SAMPLE_W-1:0] v);
		for (int j = 0; j < GROUP; j++)
			case (kind)
				0: pending_samples.push_back(v);
				1: pending_samples.push_back(SAMPLE_W'($urandom_range(4095)));
				2: pending_samples.push_back(SAMPLE_W'($urandom_range(15)));
				3: pending_samples.push_back((j == 0) ? v : '0);
				default: pending_samples.push_back(SAMPLE_W'($urandom_range(4095, 3500)));
			endcase
	endtask

	initial begin
		int groups;
		m_load = LOAD_RST;
		m_base = BASE_RST;
		m_coef = COEF_RST;
		m_expo = EXPO_RST;
		m_sum = '0;
		m_count = 0;
		send_idle = 19;
		recv_idle = 49;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed groups at reset settings
		push_group(0, 12'd0);
		push_group(0, 12'hFFF);
		push_group(3, 12'd1);
		push_group(0, 12'd2048);
		push_group(0, 12'hAAA);
		push_group(0, 12'h555);
		// pause the sender mid-stream until every reading so far is out
		while (pending_samples.size() > 25) @(posedge clk);
		hold = 1;
		while (expected_readings.size() > 0 || in_valid) @(posedge clk);
		hold = 0;
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				3: begin send_idle = 49; recv_idle = 19; end
				6: begin send_idle = 0;  recv_idle = 0;  end
				default: ;
			endcase
			case (ph)
				0: begin
					write_reg(REG_LOAD, 24'd100);
					write_reg(REG_BASE, 24'd1000000);
				end
				1: begin
					write_reg(REG_LOAD, 24'd0);
					write_reg(REG_BASE, 24'd0);
					write_reg(REG_EXPO, 24'h8000);
				end
				2: begin
					write_reg(REG_LOAD, 24'h1FFFF);
					write_reg(REG_BASE, 24'd1);
					write_reg(REG_COEF, 24'hFFFFFF);
					write_reg(REG_EXPO, 24'h7FFF);
				end
				3: write_reg(REG_COEF, 24'd0);
				4: begin
					write_reg(REG_LOAD, 24'hFFFFFF);
					write_reg(REG_BASE, 24'hFFFFFF);
					write_reg(REG_COEF, 24'd1);
					write_reg(REG_EXPO, 24'hFF0000);
				end
				5: begin
					write_reg(REG_LOAD, CFG_W'(LOAD_RST));
					write_reg(REG_BASE, CFG_W'(BASE_RST));
					write_reg(REG_COEF, CFG_W'(COEF_RST));
					write_reg(REG_EXPO, CFG_W'($unsigned(EXPO_RST)));
				end
				default: begin
					write_reg(REG_LOAD, CFG_W'($urandom_range(100000, 100)));
					write_reg(REG_BASE, CFG_W'($urandom_range(1000000, 100)));
					write_reg(REG_COEF, CFG_W'($urandom_range(24'hFFFFFF, 1)));
					write_reg(REG_EXPO, CFG_W'($urandom_range(16'hFFFF)));
				end
			endcase
			groups = 18;
			for (int g = 0; g < groups; g++)
				push_group($urandom_range(6), SAMPLE_W'($urandom_range(4095)));
			drain();
		end

		if (errors == 0) begin
			$display("gas_sensor_ppm_converter_core verification clean");
		end else begin
			$display("gas_sensor_ppm_converter_core verification failed");
		end
		$finish;
	end

endmodule
